### src/itoa_pkg.sv
// Shared types and constants of the integer to ASCII formatter.
// Used by itoa_dabble and integer_to_ascii_formatter_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int VAL_BITS   = 32;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_BITS   = 4 * BCD_DIGITS;
   localparam int STEP_W     = $clog2(VAL_BITS);
   localparam int DIGIT_W    = $clog2(BCD_DIGITS + 1);

   localparam int PAD_LIMIT = 10;
   localparam int BIN_LIMIT = 32;
   localparam int HEX_LIMIT = 8;

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;
   localparam logic [6:0] CHAR_POINT = 7'h2E;
   localparam logic [6:0] CHAR_ALPHA = 7'h37;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   typedef enum logic [2:0] {
      FMT_SDEC   = 3'd0,
      FMT_UDEC   = 3'd1,
      FMT_PDEC   = 3'd2,
      FMT_BIN    = 3'd3,
      FMT_HEX    = 3'd4,
      FMT_TENTHS = 3'd5
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_STRIP,
      ST_SIGN,
      ST_PAD,
      ST_DIGIT,
      ST_POINT,
      ST_FRAC,
      ST_RADIX
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic bin_bit;
      logic bin_nib;
      logic bcd_digit;
   } dd_ctrl_type;

   typedef struct packed {
      logic       conv_last;
      logic       bin_msb;
      logic [3:0] bin_nibble;
      logic [3:0] bcd_top;
   } dd_status_type;

endpackage

`default_nettype wire

### src/itoa_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle while step is held.
// Also shifts the binary word out by bit or nibble; depends on itoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itoa_dabble (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  itoa_pkg::dd_ctrl_type    ctrl,
   input  wire  [itoa_pkg::VAL_BITS-1:0]  load_data,
   output itoa_pkg::dd_status_type        status
);

   logic [itoa_pkg::VAL_BITS-1:0] bin_ff, bin_in;
   logic [itoa_pkg::BCD_BITS-1:0] bcd_ff, bcd_in;
   logic [itoa_pkg::BCD_BITS-1:0] bcd_adj;
   logic [itoa_pkg::STEP_W-1:0]   step_ff, step_in;

   always_comb begin
      for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      if (ctrl.load) begin
         bin_in  = load_data;
         bcd_in  = '0;
         step_in = '0;
      end else if (ctrl.step) begin
         bcd_in  = {bcd_adj[itoa_pkg::BCD_BITS-2:0], bin_ff[itoa_pkg::VAL_BITS-1]};
         bin_in  = {bin_ff[itoa_pkg::VAL_BITS-2:0], 1'b0};
         step_in = step_ff + itoa_pkg::STEP_W'(1);
      end else if (ctrl.bin_bit) begin
         bin_in = {bin_ff[itoa_pkg::VAL_BITS-2:0], 1'b0};
      end else if (ctrl.bin_nib) begin
         bin_in = {bin_ff[itoa_pkg::VAL_BITS-5:0], 4'b0};
      end else if (ctrl.bcd_digit) begin
         bcd_in = {bcd_ff[itoa_pkg::BCD_BITS-5:0], 4'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.conv_last  = (step_ff == itoa_pkg::STEP_W'(itoa_pkg::VAL_BITS - 1));
   assign status.bin_msb    = bin_ff[itoa_pkg::VAL_BITS-1];
   assign status.bin_nibble = bin_ff[itoa_pkg::VAL_BITS-1 -: 4];
   assign status.bcd_top    = bcd_ff[itoa_pkg::BCD_BITS-1 -: 4];

endmodule

`default_nettype wire

### src/integer_to_ascii_formatter_top.sv
// Top level of the integer to ASCII formatter: command port, sequencer, output word.
// Depends on itoa_pkg and itoa_dabble.
//
//   channel   ports                                  handshake
//   command   req_func, req_value, req_digits        start && !busy
//   result    rsp_ascii_char, rsp_last_char          rsp_strobe, one cycle
//
// Decimal formats: conversion (one value bit per cycle through the shift and add-3
// converter), then leading zero digits are dropped (at most 9) and the next step is
// picked, then the characters are formed. Binary and hex: the word is first shifted
// to align the requested digits, then the characters are formed. Characters leave
// through an output register in the cycle after they are formed. Synchronous reset
// clears the sequencer and strobe. The receiver cannot stall; busy holds off commands.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_top #(
   parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   output logic       busy,
   input  wire  [2:0] req_func,
   input  wire  [31:0] req_value,
   input  wire  [5:0] req_digits,
   output logic       rsp_strobe,
   output logic [6:0] rsp_ascii_char,
   output logic       rsp_last_char
);

   localparam int EFF_W = (VALUE_WIDTH < itoa_pkg::VAL_BITS) ? VALUE_WIDTH
                                                             : itoa_pkg::VAL_BITS;
   localparam logic [itoa_pkg::VAL_BITS-1:0] VALUE_MASK =
      {itoa_pkg::VAL_BITS{1'b1}} >> (itoa_pkg::VAL_BITS - EFF_W);

   itoa_pkg::state_type     state_ff, state_in;
   itoa_pkg::func_type      func_ff, func_in;
   itoa_pkg::func_type      req_fmt;
   itoa_pkg::dd_ctrl_type   dd_ctrl;
   itoa_pkg::dd_status_type dd_status;

   logic                    neg_ff, neg_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [5:0]              skip_ff, skip_in;
   logic [itoa_pkg::DIGIT_W-1:0] nd_ff, nd_in;

   logic                    strobe_ff, strobe_in;
   logic [6:0]              char_ff, char_in;
   logic                    last_ff, last_in;

   logic [itoa_pkg::VAL_BITS-1:0] value_v, value_mag, load_word;
   logic                    value_neg;
   logic                    accept;
   logic                    is_tenths;
   logic                    strip_ok;
   logic [5:0]              nd_wide;
   logic [5:0]              clamp_cnt, clamp_skip;
   logic [3:0]              nib;

   generate
      if (VALUE_WIDTH <= itoa_pkg::VAL_BITS) begin : g_sign
         assign value_neg = req_value[VALUE_WIDTH-1];
      end else begin : g_nosign
         assign value_neg = 1'b0;
      end
   endgenerate

   assign value_v   = req_value & VALUE_MASK;
   assign value_mag = value_neg ? ((~value_v + 32'd1) & VALUE_MASK) : value_v;
   assign req_fmt   = itoa_pkg::func_type'(req_func);
   assign accept    = start && !busy;
   assign busy      = (state_ff != itoa_pkg::ST_IDLE);
   assign is_tenths = (func_ff == itoa_pkg::FMT_TENTHS);
   assign nd_wide   = 6'(nd_ff);
   assign strip_ok  = (dd_status.bcd_top == 4'd0) &&
                      (nd_ff > (is_tenths ? itoa_pkg::DIGIT_W'(2) : itoa_pkg::DIGIT_W'(1)));
   assign nib       = dd_status.bin_nibble & itoa_pkg::NIBBLE_MASK;

   always_comb begin
      load_word = value_v;
      if (req_fmt == itoa_pkg::FMT_SDEC || req_fmt == itoa_pkg::FMT_TENTHS) begin
         load_word = value_mag;
      end
   end

   always_comb begin
      clamp_cnt  = '0;
      clamp_skip = '0;
      case (req_fmt)
         itoa_pkg::FMT_PDEC: begin
            clamp_cnt = (req_digits > 6'(itoa_pkg::PAD_LIMIT)) ? 6'(itoa_pkg::PAD_LIMIT)
                                                               : req_digits;
         end
         itoa_pkg::FMT_BIN: begin
            clamp_cnt  = (req_digits > 6'(itoa_pkg::BIN_LIMIT)) ? 6'(itoa_pkg::BIN_LIMIT)
                                                                : req_digits;
            clamp_skip = 6'(itoa_pkg::BIN_LIMIT) - clamp_cnt;
         end
         itoa_pkg::FMT_HEX: begin
            clamp_cnt  = (req_digits > 6'(itoa_pkg::HEX_LIMIT)) ? 6'(itoa_pkg::HEX_LIMIT)
                                                                : req_digits;
            clamp_skip = 6'(itoa_pkg::HEX_LIMIT) - clamp_cnt;
         end
         default: begin
            clamp_cnt  = '0;
            clamp_skip = '0;
         end
      endcase
   end

   itoa_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (dd_ctrl),
      .load_data (load_word),
      .status    (dd_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itoa_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_fmt)
                  itoa_pkg::FMT_SDEC, itoa_pkg::FMT_UDEC,
                  itoa_pkg::FMT_PDEC, itoa_pkg::FMT_TENTHS: state_in = itoa_pkg::ST_CONV;
                  itoa_pkg::FMT_BIN, itoa_pkg::FMT_HEX: begin
                     if (clamp_cnt != 6'd0) begin
                        state_in = itoa_pkg::ST_RADIX;
                     end
                  end
                  default: state_in = itoa_pkg::ST_IDLE;
               endcase
            end
         end
         itoa_pkg::ST_CONV: begin
            if (dd_status.conv_last) begin
               state_in = itoa_pkg::ST_STRIP;
            end
         end
         itoa_pkg::ST_STRIP: begin
            if (!strip_ok) begin
               if (neg_ff) begin
                  state_in = itoa_pkg::ST_SIGN;
               end else if (func_ff == itoa_pkg::FMT_PDEC && cnt_ff > nd_wide) begin
                  state_in = itoa_pkg::ST_PAD;
               end else begin
                  state_in = itoa_pkg::ST_DIGIT;
               end
            end
         end
         itoa_pkg::ST_SIGN: state_in = itoa_pkg::ST_DIGIT;
         itoa_pkg::ST_PAD: begin
            if (cnt_ff == nd_wide + 6'd1) begin
               state_in = itoa_pkg::ST_DIGIT;
            end
         end
         itoa_pkg::ST_DIGIT: begin
            if (is_tenths && nd_ff == itoa_pkg::DIGIT_W'(2)) begin
               state_in = itoa_pkg::ST_POINT;
            end else if (nd_ff == itoa_pkg::DIGIT_W'(1)) begin
               state_in = itoa_pkg::ST_IDLE;
            end
         end
         itoa_pkg::ST_POINT: state_in = itoa_pkg::ST_FRAC;
         itoa_pkg::ST_FRAC:  state_in = itoa_pkg::ST_IDLE;
         itoa_pkg::ST_RADIX: begin
            if (skip_ff == 6'd0 && cnt_ff == 6'd1) begin
               state_in = itoa_pkg::ST_IDLE;
            end
         end
         default: state_in = itoa_pkg::ST_IDLE;
      endcase
   end

   // outputs: converter commands and the next output word
   always_comb begin
      dd_ctrl   = '0;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = 1'b0;
      case (state_ff)
         itoa_pkg::ST_IDLE: dd_ctrl.load = accept;
         itoa_pkg::ST_CONV: dd_ctrl.step = 1'b1;
         itoa_pkg::ST_STRIP: dd_ctrl.bcd_digit = strip_ok;
         itoa_pkg::ST_SIGN: begin
            strobe_in = 1'b1;
            char_in   = itoa_pkg::CHAR_MINUS;
         end
         itoa_pkg::ST_PAD: begin
            strobe_in = 1'b1;
            char_in   = itoa_pkg::CHAR_ZERO;
         end
         itoa_pkg::ST_DIGIT: begin
            dd_ctrl.bcd_digit = 1'b1;
            strobe_in = 1'b1;
            char_in   = itoa_pkg::CHAR_ZERO + 7'(dd_status.bcd_top);
            last_in   = !is_tenths && nd_ff == itoa_pkg::DIGIT_W'(1);
         end
         itoa_pkg::ST_POINT: begin
            strobe_in = 1'b1;
            char_in   = itoa_pkg::CHAR_POINT;
         end
         itoa_pkg::ST_FRAC: begin
            strobe_in = 1'b1;
            char_in   = itoa_pkg::CHAR_ZERO + 7'(dd_status.bcd_top);
            last_in   = 1'b1;
         end
         itoa_pkg::ST_RADIX: begin
            dd_ctrl.bin_bit = (func_ff == itoa_pkg::FMT_BIN);
            dd_ctrl.bin_nib = (func_ff == itoa_pkg::FMT_HEX);
            if (skip_ff == 6'd0) begin
               strobe_in = 1'b1;
               last_in   = (cnt_ff == 6'd1);
               if (func_ff == itoa_pkg::FMT_BIN) begin
                  char_in = itoa_pkg::CHAR_ZERO + 7'(dd_status.bin_msb);
               end else if (nib < 4'd10) begin
                  char_in = itoa_pkg::CHAR_ZERO + 7'(nib);
               end else begin
                  char_in = itoa_pkg::CHAR_ALPHA + 7'(nib);
               end
            end
         end
         default: dd_ctrl = '0;
      endcase
   end

   // counters and item fields
   always_comb begin
      func_in = func_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      skip_in = skip_ff;
      nd_in   = nd_ff;
      case (state_ff)
         itoa_pkg::ST_IDLE: begin
            if (accept) begin
               func_in = req_fmt;
               neg_in  = value_neg &&
                         (req_fmt == itoa_pkg::FMT_SDEC || req_fmt == itoa_pkg::FMT_TENTHS);
               cnt_in  = clamp_cnt;
               skip_in = clamp_skip;
               nd_in   = itoa_pkg::DIGIT_W'(itoa_pkg::BCD_DIGITS);
            end
         end
         itoa_pkg::ST_STRIP: begin
            if (strip_ok) begin
               nd_in = nd_ff - itoa_pkg::DIGIT_W'(1);
            end
         end
         itoa_pkg::ST_PAD:   cnt_in = cnt_ff - 6'd1;
         itoa_pkg::ST_DIGIT: nd_in  = nd_ff - itoa_pkg::DIGIT_W'(1);
         itoa_pkg::ST_RADIX: begin
            if (skip_ff != 6'd0) begin
               skip_in = skip_ff - 6'd1;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         default: nd_in = nd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= itoa_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      func_ff <= func_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      skip_ff <= skip_in;
      nd_ff   <= nd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !last_ff) |-> busy)
      else $error("word without last mark while sequencer idle");

   a_quiet_in_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itoa_pkg::ST_CONV && $past(state_ff == itoa_pkg::ST_CONV)) |-> !strobe_ff)
      else $error("word strobed during conversion");

   a_pad_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itoa_pkg::ST_PAD) |-> (cnt_ff > nd_wide))
      else $error("padding beyond requested width");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (strobe_in && last_in) |=> !busy)
      else $error("sequencer still busy after last word");

endmodule

`default_nettype wire
